// File: hdl/pislip_pkg.sv
// ---------------------------------------------------------------------------
// pislip_pkg
// Shared types, constants and helpers for the priority iSLIP crossbar
// scheduler: request and match formats, controller/datapath command bundle.
// ---------------------------------------------------------------------------
package pislip_pkg;

    // Switch geometry
    localparam int NUM_INPUTS     = 4;
    localparam int NUM_OUTPUTS    = 4;
    localparam int NUM_PRIORITIES = 4;
    localparam int MAX_ROUNDS     = 8;

    localparam int IDX_W  = 2;   // input or output index
    localparam int PRI_W  = 2;   // priority index
    localparam int ITER_W = 3;   // round counter, 0..MAX_ROUNDS-1

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ITERATIONS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PRIORITIES = 2'd1;

    // One cell time of request matrices, bit input*4+output
    typedef struct packed {
        logic [15:0] requests_pri0;
        logic [15:0] requests_pri1;
        logic [15:0] requests_pri2;
        logic [15:0] requests_pri3;
    } t_req_item;

    // One crossbar matching
    typedef struct packed {
        logic [3:0] match_valid;
        logic [7:0] match_input;
        logic [7:0] match_priority;
        logic [2:0] match_count;
    } t_match_item;

    // Controller to datapath commands
    typedef struct packed {
        logic             start;        // load requests, clear matching
        logic             step;         // run one request-grant-accept round
        logic             first_round;  // round zero of this priority
        logic             load_out;     // capture matching into result register
        logic [PRI_W-1:0] pri;          // priority being scheduled
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic made;                     // current round made at least one match
    } t_dp_sts;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_pick;

    // Round-robin pick: first set bit of mask starting one past ptr
    function automatic t_pick rr_pick(input logic [3:0] mask, input logic [IDX_W-1:0] ptr);
        t_pick            res;
        logic [IDX_W-1:0] cand;
        res = '0;
        for (int k = 1; k <= 4; k++) begin
            cand = ptr + IDX_W'(k);
            if (!res.found && mask[cand]) begin
                res.found = 1'b1;
                res.idx   = cand;
            end
        end
        return res;
    endfunction

endpackage

// File: hdl/pislip_dp.sv
// ---------------------------------------------------------------------------
// pislip_dp
// Scheduler datapath: request store, per-priority grant and accept pointers,
// one grant+accept round per step, matching state and result register.
// ---------------------------------------------------------------------------
module pislip_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pislip_pkg::t_dp_cmd    i_cmd,
    output pislip_pkg::t_dp_sts    o_sts,
    input  pislip_pkg::t_req_item  i_req,
    output pislip_pkg::t_match_item o_res
);

    localparam int NI = pislip_pkg::NUM_INPUTS;
    localparam int NO = pislip_pkg::NUM_OUTPUTS;
    localparam int NP = pislip_pkg::NUM_PRIORITIES;
    localparam int IW = pislip_pkg::IDX_W;

    logic [15:0]   r_req [NP];
    logic [IW-1:0] r_gptr [NO][NP];
    logic [IW-1:0] r_aptr [NI][NP];
    logic [NI-1:0] r_in_used;
    logic [NO-1:0] r_out_used;
    logic [IW-1:0] r_out_in [NO];
    logic [pislip_pkg::PRI_W-1:0] r_out_pri [NO];
    pislip_pkg::t_match_item r_res;

    logic [15:0]   req;
    logic [NO-1:0] grant [NI];
    logic [NI-1:0] acc_valid;
    logic [IW-1:0] acc_out [NI];
    pislip_pkg::t_match_item res_build;

    // Grant phase then accept phase for the current priority
    always_comb begin
        logic [NI-1:0]     mask;
        pislip_pkg::t_pick pick;
        req = r_req[i_cmd.pri];
        for (int i = 0; i < NI; i++) begin
            grant[i]   = '0;
            acc_valid[i] = 1'b0;
            acc_out[i] = '0;
        end
        for (int o = 0; o < NO; o++) begin
            for (int i = 0; i < NI; i++) begin
                mask[i] = !r_in_used[i] && req[i*NO + o];
            end
            pick = pislip_pkg::rr_pick(mask, r_gptr[o][i_cmd.pri]);
            if (!r_out_used[o] && pick.found) begin
                grant[pick.idx][o] = 1'b1;
            end
        end
        for (int i = 0; i < NI; i++) begin
            pick = pislip_pkg::rr_pick(grant[i], r_aptr[i][i_cmd.pri]);
            if (!r_in_used[i] && pick.found) begin
                acc_valid[i] = 1'b1;
                acc_out[i]   = pick.idx;
            end
        end
    end

    assign o_sts.made = |acc_valid;

    // Pointers reset to zero; accept pointers advance on accepts, grant pointers on first-round accepts only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int o = 0; o < NO; o++) begin
                for (int p = 0; p < NP; p++) begin
                    r_gptr[o][p] <= '0;
                end
            end
            for (int i = 0; i < NI; i++) begin
                for (int p = 0; p < NP; p++) begin
                    r_aptr[i][p] <= '0;
                end
            end
        end else if (i_cmd.step) begin
            for (int i = 0; i < NI; i++) begin
                if (acc_valid[i]) begin
                    r_aptr[i][i_cmd.pri] <= acc_out[i];
                    if (i_cmd.first_round) begin
                        r_gptr[acc_out[i]][i_cmd.pri] <= IW'(i);
                    end
                end
            end
        end
    end

    // Hold requests and build the matching
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req[0]   <= i_req.requests_pri0;
            r_req[1]   <= i_req.requests_pri1;
            r_req[2]   <= i_req.requests_pri2;
            r_req[3]   <= i_req.requests_pri3;
            r_in_used  <= '0;
            r_out_used <= '0;
        end else if (i_cmd.step) begin
            for (int i = 0; i < NI; i++) begin
                if (acc_valid[i]) begin
                    r_in_used[i]           <= 1'b1;
                    r_out_used[acc_out[i]] <= 1'b1;
                    r_out_in[acc_out[i]]   <= IW'(i);
                    r_out_pri[acc_out[i]]  <= i_cmd.pri;
                end
            end
        end
    end

    // Pack the result; unmatched outputs read as zero
    always_comb begin
        res_build = '0;
        for (int o = 0; o < NO; o++) begin
            res_build.match_valid[o] = r_out_used[o];
            res_build.match_input[2*o +: 2]    = r_out_used[o] ? r_out_in[o] : 2'd0;
            res_build.match_priority[2*o +: 2] = r_out_used[o] ? r_out_pri[o] : 2'd0;
        end
        res_build.match_count = 3'($countones(r_out_used));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_res <= res_build;
        end
    end

    assign o_res = r_res;

endmodule

// File: hdl/pislip_ctrl.sv
// ---------------------------------------------------------------------------
// pislip_ctrl
// Scheduler controller: configuration registers, priority and round
// sequencing, request and result handshakes.
// ---------------------------------------------------------------------------
module pislip_ctrl (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pislip_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pislip_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output pislip_pkg::t_dp_cmd                    o_cmd,
    input  pislip_pkg::t_dp_sts                    i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    localparam int PW = pislip_pkg::PRI_W;
    localparam int TW = pislip_pkg::ITER_W;

    t_state        r_state;
    logic [PW-1:0] r_pri;
    logic [TW-1:0] r_iter;
    logic          r_out_valid;
    logic [3:0]    r_num_iter;
    logic [2:0]    r_act_pri;

    logic [TW-1:0] last_iter;
    logic [PW-1:0] last_pri;
    logic          out_free;
    logic          round_end;

    // Clamp configuration into usable ranges
    always_comb begin
        if (r_num_iter == 4'd0) begin
            last_iter = '0;
        end else if (r_num_iter > 4'(pislip_pkg::MAX_ROUNDS)) begin
            last_iter = TW'(pislip_pkg::MAX_ROUNDS - 1);
        end else begin
            last_iter = TW'(r_num_iter - 4'd1);
        end
        if (r_act_pri == 3'd0) begin
            last_pri = '0;
        end else if (r_act_pri > 3'(pislip_pkg::NUM_PRIORITIES)) begin
            last_pri = PW'(pislip_pkg::NUM_PRIORITIES - 1);
        end else begin
            last_pri = PW'(r_act_pri - 3'd1);
        end
    end

    assign out_free  = !r_out_valid || i_out_ready;
    assign round_end = !i_sts.made || (r_iter == last_iter);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

    // Commands to the datapath
    always_comb begin
        o_cmd             = '0;
        o_cmd.start       = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step        = (r_state == S_RUN);
        o_cmd.first_round = (r_iter == '0);
        o_cmd.load_out    = (r_state == S_DONE) && out_free;
        o_cmd.pri         = r_pri;
    end

    // State, counters, configuration and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pri       <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
            r_num_iter  <= 4'd1;
            r_act_pri   <= 3'd4;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    pislip_pkg::CFG_NUM_ITERATIONS:    r_num_iter <= i_cfg_data;
                    pislip_pkg::CFG_ACTIVE_PRIORITIES: r_act_pri  <= i_cfg_data[2:0];
                    default: ;
                endcase
            end

            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_RUN;
                        r_pri   <= '0;
                        r_iter  <= '0;
                    end
                end
                S_RUN: begin
                    if (round_end) begin
                        r_iter <= '0;
                        if (r_pri == last_pri) begin
                            r_state <= S_DONE;
                        end else begin
                            r_pri <= r_pri + PW'(1);
                        end
                    end else begin
                        r_iter <= r_iter + TW'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/priority_islip_scheduler.sv
// A request is accepted while idle; the controller then runs one iSLIP round
// per step (between P and P*R rounds for P active priorities and R rounds) and
// registers the matching once the output is free; the result shows the cycle
// after that. With a single shared grant/accept round unit, no new request is
// taken until the matching is registered. Synchronous active-low reset clears
// all pointers to zero, restores num_iterations=1, active_priorities=4 at once.
// ---------------------------------------------------------------------------
// priority_islip_scheduler
// Priority iSLIP crossbar scheduler: controller plus round datapath.
// ---------------------------------------------------------------------------
module priority_islip_scheduler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  pislip_pkg::t_req_item              i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output pislip_pkg::t_match_item            o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pislip_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pislip_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    pislip_pkg::t_dp_cmd cmd;
    pislip_pkg::t_dp_sts sts;

    // Sequence priorities and rounds
    pislip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Run grant/accept rounds and hold the matching
    pislip_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_req   (i_in_data),
        .o_res   (o_out_data)
    );

`ifndef NO_ASSERTIONS
    // Count agrees with the matched outputs
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.match_count == 3'($countones(o_out_data.match_valid))))
        else $error("match_count disagrees with match_valid");

    // Busy after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while scheduler busy");

    // Result register loads only after the rounds finish
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !cmd.step && !cmd.start)
        else $error("result captured while rounds active");
`endif

endmodule
